@@ sv/bes_pkg.sv @@
// Shared constants and register indexes for the Bezier envelope curve shaper.
package bes_pkg;

  localparam int FIELD_W          = 17;
  localparam int TDATA_W          = 24;
  localparam int APB_ADDR_W       = 3;
  localparam int APB_DATA_W       = 32;
  localparam int BISECT_STEPS_DEF = 20;
  localparam int FRAC_BITS_DEF    = 16;

  localparam logic [FIELD_W-1:0] Q16_ONE   = 17'd65536;
  localparam logic [FIELD_W-1:0] CURVE_MID = 17'd32768;

  // Register index, taken from paddr bit 2.
  typedef enum logic {
    REG_CURVE_AMOUNT = 1'b0
  } reg_idx_e;

endpackage

@@ sv/bes_cfg.sv @@
// APB register file for the bend amount and its mapping to the control height.
module bes_cfg import bes_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [FIELD_W-1:0]    cy16_o
);

  logic [FIELD_W-1:0] curve_q, curve_d;
  logic               wr_en;
  logic signed [FIELD_W:0] curve_ext;
  logic signed [FIELD_W:0] curve_sat;
  logic signed [FIELD_W:0] cy_sum;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready &&
                  (reg_idx_e'(paddr[2]) == REG_CURVE_AMOUNT);

  always_comb begin
    curve_d = curve_q;
    if (wr_en) begin
      curve_d = pwdata[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q <= '0;
    end else begin
      curve_q <= curve_d;
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_CURVE_AMOUNT: prdata = {{(APB_DATA_W-FIELD_W){curve_q[FIELD_W-1]}}, curve_q};
      default:          prdata = '0;
    endcase
  end

  // Saturate to +-1.0, then offset to 0..1.0 in Q0.16.
  assign curve_ext = {curve_q[FIELD_W-1], curve_q};
  always_comb begin
    priority if (curve_ext > $signed({1'b0, CURVE_MID})) begin
      curve_sat = $signed({1'b0, CURVE_MID});
    end else if (curve_ext < -$signed({1'b0, CURVE_MID})) begin
      curve_sat = -$signed({1'b0, CURVE_MID});
    end else begin
      curve_sat = curve_ext;
    end
  end
  assign cy_sum = curve_sat + $signed({1'b0, CURVE_MID});
  assign cy16_o = cy_sum[FIELD_W-1:0];

endmodule

@@ sv/bes_cell.sv @@
// One bisection step: three register ranks that evaluate x(mid) and narrow the bracket.
module bes_cell import bes_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [FRAC_BITS:0]   lo_i,
  input  logic [FRAC_BITS:0]   hi_i,
  input  logic [FRAC_BITS:0]   x_i,
  output logic                 valid_o,
  output logic [FRAC_BITS:0]   lo_o,
  output logic [FRAC_BITS:0]   hi_o,
  output logic [FRAC_BITS:0]   x_o,
  output logic [FRAC_BITS+1:0] p_o,
  output logic [FRAC_BITS+1:0] c_o
);

  localparam int W  = FRAC_BITS + 1;
  localparam int PW = 2 * W;
  localparam int XW = W + 3;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [W:0]    sum;
  logic [W-1:0]  mid;
  logic [W-1:0]  um;

  logic          s1_valid_q, s2_valid_q;
  logic [W-1:0]  s1_t_q, s1_lo_q, s1_hi_q, s1_x_q;
  logic [PW-1:0] s1_ut_q, s1_tt_q;
  logic [W-1:0]  s2_t_q, s2_lo_q, s2_hi_q, s2_x_q;
  logic [W:0]    s2_p_q;
  logic [PW-1:0] s2_c2_q;

  logic [W:0]    cube;
  logic [XW-1:0] three_p;
  logic [XW-1:0] xt;
  logic          below;

  assign sum = {1'b0, lo_i} + {1'b0, hi_i};
  assign mid = sum[W:1];
  assign um  = ONE - mid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      valid_o    <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      valid_o    <= s2_valid_q;
    end
  end

  // Rank 1: midpoint and the two first products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_t_q  <= mid;
      s1_lo_q <= lo_i;
      s1_hi_q <= hi_i;
      s1_x_q  <= x_i;
      s1_ut_q <= PW'(um) * PW'(mid);
      s1_tt_q <= PW'(mid) * PW'(mid);
    end
  end

  // Rank 2: u*t scaled, and t^2 times t.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_t_q  <= s1_t_q;
      s2_lo_q <= s1_lo_q;
      s2_hi_q <= s1_hi_q;
      s2_x_q  <= s1_x_q;
      s2_p_q  <= s1_ut_q[FRAC_BITS +: W+1];
      s2_c2_q <= PW'(s1_tt_q[FRAC_BITS +: W]) * PW'(s1_t_q);
    end
  end

  // Rank 3: x(t) = 1.5*u*t + t^3, compare and narrow.
  assign cube    = s2_c2_q[FRAC_BITS +: W+1];
  assign three_p = {1'b0, s2_p_q, 1'b0} + {2'b00, s2_p_q};
  assign xt      = (three_p >> 1) + {2'b00, cube};
  assign below   = xt < {3'b000, s2_x_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_o <= below ? s2_t_q : s2_lo_q;
      hi_o <= below ? s2_hi_q : s2_t_q;
      x_o  <= s2_x_q;
      p_o  <= s2_p_q;
      c_o  <= cube;
    end
  end

endmodule

@@ sv/bezier_envelope_curve_shaper.sv @@
// Top level of the Bezier envelope curve shaper: bisection cell chain and output stage.
//
// Usage: each request on the s_axis channel carries a phase in unsigned Q0.16
// (65536 = 1.0; larger values clamp to 1.0). The block inverts the Bezier x(t)
// with control abscissa 0.5 by bisection, then returns the shaped level y(t) on
// the m_axis channel, unsigned Q0.16 clamped to 0..1.0.
// The bend amount is written over APB at byte address 0 (signed Q1.15, read back
// sign-extended); write it only while no request is in flight.
//
// Structure: a row of BISECT_STEPS identical cells. Each cell holds one bracket
// [lo, hi] per request in flight and takes three register ranks (products, cube,
// compare), then hands the narrowed bracket to its neighbor. After the row, one
// rank forms 3*cy*u*t and one rank adds t^3, shifts and clamps into the output
// register.
// Throughput: one request per cycle while no result is held, set by the fully pipelined cell chain.
// Reset: clears all valid flags and the bend amount to 0 (straight line).
// Stall: while a result waits and m_axis_tready is low, the whole chain holds
// and s_axis_tready drops; when the receiver takes the result, a new request is
// accepted in the same cycle.
module bezier_envelope_curve_shaper import bes_pkg::*; #(
  parameter int BISECT_STEPS = BISECT_STEPS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,   // [16:0] phase
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // [16:0] level
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int W   = FRAC_BITS + 1;
  localparam int PRW = W + 20;
  localparam int YW  = W + 5;
  localparam int LW  = YW + 16;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic               en;
  logic [FIELD_W-1:0] cy16;
  logic [FIELD_W-1:0] phase;
  logic [FIELD_W-1:0] phase_clamp;
  logic [W-1:0]       x_in;

  logic         vld_c [BISECT_STEPS+1];
  logic [W-1:0] lo_c  [BISECT_STEPS+1];
  logic [W-1:0] hi_c  [BISECT_STEPS+1];
  logic [W-1:0] x_c   [BISECT_STEPS+1];
  logic [W:0]   p_c   [BISECT_STEPS];
  logic [W:0]   c_c   [BISECT_STEPS];

  logic               y1_valid_q;
  logic [PRW-1:0]     y1_prod_q;
  logic [W:0]         y1_c_q;
  logic [18:0]        cy3;
  logic [YW-1:0]      y_sum;
  logic [LW-1:0]      lvl_wide;
  logic [FIELD_W-1:0] level;
  logic               m_valid_q;
  logic [FIELD_W-1:0] m_level_q;

  // Advance the whole pipeline unless a result is held.
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  bes_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cy16_o  (cy16)
  );

  // Clamp the phase to 1.0 and move it to the internal fraction width.
  assign phase       = s_axis_tdata[FIELD_W-1:0];
  assign phase_clamp = (phase > Q16_ONE) ? Q16_ONE : phase;

  generate
    if (FRAC_BITS >= 16) begin : g_x_up
      assign x_in = W'({phase_clamp, {(FRAC_BITS-16+1){1'b0}}} >> 1);
    end else begin : g_x_dn
      assign x_in = phase_clamp[16 -: W];
    end
  endgenerate

  assign vld_c[0] = s_axis_tvalid && s_axis_tready;
  assign lo_c[0]  = '0;
  assign hi_c[0]  = ONE;
  assign x_c[0]   = x_in;

  generate
    for (genvar i = 0; i < BISECT_STEPS; i++) begin : g_cell
      bes_cell #(
        .FRAC_BITS (FRAC_BITS)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (vld_c[i]),
        .lo_i    (lo_c[i]),
        .hi_i    (hi_c[i]),
        .x_i     (x_c[i]),
        .valid_o (vld_c[i+1]),
        .lo_o    (lo_c[i+1]),
        .hi_o    (hi_c[i+1]),
        .x_o     (x_c[i+1]),
        .p_o     (p_c[i]),
        .c_o     (c_c[i])
      );
    end
  endgenerate

  // The last cell's u*t and t^3 belong to the final midpoint: reuse them.
  assign cy3 = {2'b00, cy16} + {1'b0, cy16, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else if (en) begin
      y1_valid_q <= vld_c[BISECT_STEPS];
      m_valid_q  <= y1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y1_prod_q <= PRW'(cy3) * PRW'(p_c[BISECT_STEPS-1]);
      y1_c_q    <= c_c[BISECT_STEPS-1];
    end
  end

  assign y_sum = YW'(y1_prod_q[PRW-1:16]) + YW'(y1_c_q);

  generate
    if (FRAC_BITS >= 16) begin : g_y_dn
      assign lvl_wide = LW'(y_sum >> (FRAC_BITS - 16));
    end else begin : g_y_up
      assign lvl_wide = LW'(y_sum) << (16 - FRAC_BITS);
    end
  endgenerate

  assign level = (lvl_wide > LW'(Q16_ONE)) ? Q16_ONE : lvl_wide[FIELD_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_level_q <= level;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(TDATA_W-FIELD_W){1'b0}}, m_level_q};

  // A held result must block new requests.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("request accepted while result held");

  // A result appears only after the final product rank held a request.
  a_out_from_y1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(y1_valid_q))
    else $error("result without a request in the product rank");

  // Level never exceeds 1.0.
  a_level_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[FIELD_W-1:0] <= Q16_ONE))
    else $error("level above 1.0");

  // The final bracket never inverts.
  a_bracket_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_c[BISECT_STEPS] |-> (lo_c[BISECT_STEPS] <= hi_c[BISECT_STEPS]))
    else $error("bisection bracket inverted");

endmodule
